// ----- sv/swla_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swla_pkg: shared types and constants for the stopwatch with lap store
// Command codes, time limits, alarm step sizes and the control structs that
// pass between the timer, the lap cells and the top level.
// ----------------------------------------------------------------------------
package swla_pkg;

    // Lap store geometry.
    localparam int LAP_DEPTH   = 16;
    localparam int FILL_W      = $clog2(LAP_DEPTH);
    localparam int SEL_SPAN    = (LAP_DEPTH < 16) ? LAP_DEPTH : 16;
    localparam int PRINT_TURNS = 6;

    // Field widths.
    localparam int MS_W   = 29;
    localparam int CMD_W  = 4;
    localparam int ELAP_W = 10;
    localparam int SEL_W  = 4;
    localparam int LAPS_W = 16;
    localparam int HELD_W = 4;
    localparam int SCR_W  = 5;
    localparam int SUM_W  = MS_W + 2;

    // Times in milliseconds.
    localparam logic [MS_W-1:0] LIMIT_MS      = MS_W'(99 * 1000 * 3600);
    localparam logic [MS_W-1:0] ALARM_DEFAULT = MS_W'(25 * 1000);
    localparam int              HOUR_MS       = 60 * 60 * 1000;
    localparam int              MINUTE_MS     = 60 * 1000;
    localparam int              SECOND_MS     = 1 * 1000;
    localparam logic [LAPS_W-1:0] LAPS_MAX    = '1;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK        = 4'd0,
        CMD_RUN         = 4'd1,
        CMD_CLEAR       = 4'd2,
        CMD_LAP         = 4'd3,
        CMD_HOUR_UP     = 4'd4,
        CMD_HOUR_DOWN   = 4'd5,
        CMD_MINUTE_UP   = 4'd6,
        CMD_MINUTE_DOWN = 4'd7,
        CMD_SECOND_UP   = 4'd8,
        CMD_SECOND_DOWN = 4'd9,
        CMD_SCROLL_DOWN = 4'd10,
        CMD_SCROLL_UP   = 4'd11
    } t_cmd;

    // Control for every cell of the lap row.
    typedef struct packed {
        logic shift;
        logic clear;
    } t_lap_ctl;

    // Timer results for one beat.
    typedef struct packed {
        logic [MS_W-1:0] total;
        logic [MS_W-1:0] alarm;
        logic            fired;
        logic            running;
    } t_timer_res;

    // Signed alarm step for an adjust command, zero for anything else.
    function automatic logic signed [SUM_W-1:0] alarm_delta(input logic [CMD_W-1:0] cmd);
        logic signed [SUM_W-1:0] d;
        d = '0;
        case (cmd)
            CMD_HOUR_UP:     d = SUM_W'(HOUR_MS);
            CMD_HOUR_DOWN:   d = -SUM_W'(HOUR_MS);
            CMD_MINUTE_UP:   d = SUM_W'(MINUTE_MS);
            CMD_MINUTE_DOWN: d = -SUM_W'(MINUTE_MS);
            CMD_SECOND_UP:   d = SUM_W'(SECOND_MS);
            CMD_SECOND_DOWN: d = -SUM_W'(SECOND_MS);
            default:         d = '0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

// ----- sv/swla_lap_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swla_lap_cell: one slot of the lap shift store
// Holds one lap total, takes its neighbour's value on a lap beat and clears
// on a watch reset. Shows both its held and its next value.
// ----------------------------------------------------------------------------
module swla_lap_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire swla_pkg::t_lap_ctl         i_ctl,
    input  wire logic [swla_pkg::MS_W-1:0]  i_prev,
    output logic      [swla_pkg::MS_W-1:0]  o_value,
    output logic      [swla_pkg::MS_W-1:0]  o_next
);

    logic [swla_pkg::MS_W-1:0] r_value;
    logic [swla_pkg::MS_W-1:0] n_value;

    // Clear wins over shift; otherwise hold.
    always_comb begin
        n_value = r_value;
        if (i_ctl.clear) begin
            n_value = '0;
        end else if (i_ctl.shift) begin
            n_value = i_prev;
        end
    end

    // Slot register, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;
    assign o_next  = n_value;

endmodule
`default_nettype wire

// ----- sv/swla_timer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swla_timer: running total, run flag and alarm
// Applies one command per accepted beat to the total and the alarm, wraps
// both at the 99 hour limit and raises the one-shot alarm flag.
// ----------------------------------------------------------------------------
module swla_timer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  wire logic [swla_pkg::CMD_W-1:0]   i_command,
    input  wire logic [swla_pkg::ELAP_W-1:0]  i_elapsed_ms,
    output logic      [swla_pkg::MS_W-1:0]    o_total,
    output swla_pkg::t_timer_res              o_res
);

    logic [swla_pkg::MS_W-1:0]         r_total;
    logic [swla_pkg::MS_W-1:0]         r_alarm;
    logic                              r_armed;
    logic                              r_run;

    logic [swla_pkg::MS_W-1:0]         n_total;
    logic [swla_pkg::MS_W-1:0]         n_alarm;
    logic                              n_armed;
    logic                              n_run;
    logic                              adjust;
    logic                              fired;
    logic signed [swla_pkg::SUM_W-1:0] alarm_sum;

    // Command decode and next state.
    always_comb begin
        n_total = r_total;
        n_run   = r_run;
        n_armed = r_armed;
        adjust  = 1'b0;
        if (i_step) begin
            unique case (i_command) inside
                swla_pkg::CMD_TICK: begin
                    if (r_run) begin
                        n_total = r_total + swla_pkg::MS_W'(i_elapsed_ms);
                    end
                end
                swla_pkg::CMD_RUN: begin
                    n_run = !r_run;
                end
                swla_pkg::CMD_CLEAR: begin
                    n_run   = 1'b0;
                    n_total = '0;
                    n_armed = 1'b1;
                end
                swla_pkg::CMD_HOUR_UP, swla_pkg::CMD_HOUR_DOWN,
                swla_pkg::CMD_MINUTE_UP, swla_pkg::CMD_MINUTE_DOWN,
                swla_pkg::CMD_SECOND_UP, swla_pkg::CMD_SECOND_DOWN: begin
                    adjust = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // Alarm step: a result below zero or past the limit becomes zero.
        alarm_sum = $signed({2'b00, r_alarm}) + swla_pkg::alarm_delta(i_command);
        n_alarm   = r_alarm;
        if (adjust) begin
            n_armed = 1'b1;
            if (alarm_sum[swla_pkg::SUM_W-1] ||
                (alarm_sum[swla_pkg::SUM_W-2:0] >
                 (swla_pkg::SUM_W-1)'(swla_pkg::LIMIT_MS))) begin
                n_alarm = '0;
            end else begin
                n_alarm = alarm_sum[swla_pkg::MS_W-1:0];
            end
        end

        // Total wraps past the limit.
        if (n_total > swla_pkg::LIMIT_MS) begin
            n_total = '0;
        end

        // One-shot alarm.
        fired = i_step && n_armed && (n_total > n_alarm);
        if (fired) begin
            n_armed = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_alarm <= swla_pkg::ALARM_DEFAULT;
            r_armed <= 1'b1;
            r_run   <= 1'b0;
        end else begin
            r_total <= n_total;
            r_alarm <= n_alarm;
            r_armed <= n_armed;
            r_run   <= n_run;
        end
    end

    assign o_total       = r_total;
    assign o_res.total   = n_total;
    assign o_res.alarm   = n_alarm;
    assign o_res.fired   = fired;
    assign o_res.running = n_run;

`ifndef NO_ASSERTIONS
    a_total_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= swla_pkg::LIMIT_MS)
        else $error("total beyond the 99 hour limit");

    a_alarm_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alarm <= swla_pkg::LIMIT_MS)
        else $error("alarm beyond the 99 hour limit");

    a_fire_disarms : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fired |=> !r_armed)
        else $error("alarm still armed after firing");

    a_fire_needs_arm : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !adjust && i_command != swla_pkg::CMD_CLEAR && !r_armed) |-> !fired)
        else $error("alarm fired while disarmed");
`endif

endmodule
`default_nettype wire

// ----- sv/stopwatch_lap_alarm_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stopwatch_lap_alarm_unit: millisecond stopwatch with lap store and alarm
// One command per input beat; one result beat per command.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_stall   | command, elapsed, select
//   out     | output    | o_out_valid / i_out_stall | totals, alarm, lap state
//
// The timer and the lap row update in the cycle the beat is accepted, and
// the result sits in the output register from the next cycle. A new beat
// is accepted every cycle while the output register is empty or being
// taken. Reset is synchronous and clears every lap slot at once, with no
// clearing pass. A stalled output holds its beat and stalls the input.
// ----------------------------------------------------------------------------
module stopwatch_lap_alarm_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [swla_pkg::CMD_W-1:0]    i_command,
    input  wire logic [swla_pkg::ELAP_W-1:0]   i_elapsed_ms,
    input  wire logic [swla_pkg::SEL_W-1:0]    i_lap_select,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [swla_pkg::MS_W-1:0]     o_watch_ms,
    output logic      [swla_pkg::MS_W-1:0]     o_alarm_ms,
    output logic                               o_alarm_fired,
    output logic                               o_running,
    output logic      [swla_pkg::LAPS_W-1:0]   o_laps_taken,
    output logic      [swla_pkg::HELD_W-1:0]   o_laps_held,
    output logic signed [swla_pkg::SCR_W-1:0]  o_scroll_offset,
    output logic      [swla_pkg::MS_W-1:0]     o_lap_value_ms
);

    localparam int FW = swla_pkg::FILL_W;

    logic                          accept;
    swla_pkg::t_lap_ctl            lap_ctl;
    swla_pkg::t_timer_res          timer_res;
    logic [swla_pkg::MS_W-1:0]     cur_total;
    logic [swla_pkg::MS_W-1:0]     cell_value [swla_pkg::LAP_DEPTH];
    logic [swla_pkg::MS_W-1:0]     cell_next  [swla_pkg::LAP_DEPTH];

    logic [swla_pkg::LAPS_W-1:0]   r_laps;
    logic [FW-1:0]                 r_fill;
    logic [FW-1:0]                 r_scroll;
    logic [swla_pkg::LAPS_W-1:0]   n_laps;
    logic [FW-1:0]                 n_fill;
    logic [FW-1:0]                 n_scroll;
    logic [swla_pkg::MS_W-1:0]     n_lap_value;
    logic [FW+3:0]                 fill_wide;
    logic [FW+4:0]                 scroll_wide;

    logic                          r_out_valid;
    swla_pkg::t_timer_res          r_res;
    logic [swla_pkg::LAPS_W-1:0]   r_out_laps;
    logic [swla_pkg::HELD_W-1:0]   r_out_held;
    logic [swla_pkg::SCR_W-1:0]    r_out_scroll;
    logic [swla_pkg::MS_W-1:0]     r_out_lap_value;

    // Input beat is taken whenever the output register can move.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // Row-wide control for the lap cells.
    assign lap_ctl.shift = accept && (i_command == swla_pkg::CMD_LAP);
    assign lap_ctl.clear = accept && (i_command == swla_pkg::CMD_CLEAR);

    swla_timer u_timer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (accept),
        .i_command    (i_command),
        .i_elapsed_ms (i_elapsed_ms),
        .o_total      (cur_total),
        .o_res        (timer_res)
    );

    // Lap row: slot 0 takes the current total, each later slot its neighbour.
    for (genvar k = 0; k < swla_pkg::LAP_DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            swla_lap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (lap_ctl),
                .i_prev  (cur_total),
                .o_value (cell_value[k]),
                .o_next  (cell_next[k])
            );
        end else begin : g_body
            swla_lap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (lap_ctl),
                .i_prev  (cell_value[k-1]),
                .o_value (cell_value[k]),
                .o_next  (cell_next[k])
            );
        end
    end

    // Lap counters and scroll position.
    always_comb begin
        n_laps   = r_laps;
        n_fill   = r_fill;
        n_scroll = r_scroll;
        if (accept) begin
            unique case (i_command)
                swla_pkg::CMD_CLEAR: begin
                    n_laps   = '0;
                    n_fill   = '0;
                    n_scroll = '0;
                end
                swla_pkg::CMD_LAP: begin
                    if (r_laps != swla_pkg::LAPS_MAX) begin
                        n_laps = r_laps + 1'b1;
                    end
                    if (r_fill < FW'(swla_pkg::LAP_DEPTH - 1)) begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_scroll = '0;
                end
                swla_pkg::CMD_SCROLL_DOWN: begin
                    if (r_scroll != '0) begin
                        n_scroll = r_scroll - 1'b1;
                    end
                end
                swla_pkg::CMD_SCROLL_UP: begin
                    // Scroll magnitude rises only while under fill minus the visible rows plus one.
                    if (({1'b0, r_scroll} + (FW+1)'(swla_pkg::PRINT_TURNS - 1)) <
                        {1'b0, r_fill}) begin
                        n_scroll = r_scroll + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Selected slot after this beat; slots beyond the store read as zero.
    always_comb begin
        n_lap_value = '0;
        for (int k = 0; k < swla_pkg::SEL_SPAN; k++) begin
            if (i_lap_select == swla_pkg::SEL_W'(k)) begin
                n_lap_value = cell_next[k];
            end
        end
    end

    assign fill_wide   = (FW+4)'(n_fill);
    assign scroll_wide = (FW+5)'(n_scroll);

    // Counter state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_laps      <= '0;
            r_fill      <= '0;
            r_scroll    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_laps   <= n_laps;
            r_fill   <= n_fill;
            r_scroll <= n_scroll;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res           <= timer_res;
            r_out_laps      <= n_laps;
            r_out_held      <= fill_wide[swla_pkg::HELD_W-1:0];
            r_out_scroll    <= swla_pkg::SCR_W'(0) - scroll_wide[swla_pkg::SCR_W-1:0];
            r_out_lap_value <= n_lap_value;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_watch_ms      = r_res.total;
    assign o_alarm_ms      = r_res.alarm;
    assign o_alarm_fired   = r_res.fired;
    assign o_running       = r_res.running;
    assign o_laps_taken    = r_out_laps;
    assign o_laps_held     = r_out_held;
    assign o_scroll_offset = $signed(r_out_scroll);
    assign o_lap_value_ms  = r_out_lap_value;

`ifndef NO_ASSERTIONS
    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(swla_pkg::LAP_DEPTH - 1))
        else $error("lap fill index beyond the store");

    a_scroll_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scroll <= r_fill)
        else $error("scroll magnitude exceeds the laps held");

    a_clear_empties : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == swla_pkg::CMD_CLEAR) |=>
        (r_fill == '0 && r_laps == '0 && cell_value[0] == '0))
        else $error("watch reset left lap state behind");

    a_lap_captures : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == swla_pkg::CMD_LAP) |=> (cell_value[0] == $past(cur_total)))
        else $error("lap slot did not take the running total");
`endif

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for stopwatch_lap_alarm_unit
// A queue of command beats feeds a bursty driver. A predictor steps its own
// copy of the watch for every accepted beat. A monitor compares each result
// beat, field by field, with the oldest prediction. The stimulus runs in
// this order: a short directed pass, an alarm sweep to the 99 h ceiling,
// mixed random command sequences with random stalls and one long output
// hold, and a lap run long enough to fill the store and drop its oldest
// entries, followed by scrolling across the full store.
// ----------------------------------------------------------------------------
module tb;

    // Spare command codes, which the watch ignores.
    localparam logic [swla_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 4'd12;
    localparam logic [swla_pkg::CMD_W-1:0] CMD_SPARE_LAST  = 4'd15;

    localparam int     ELAP_MAX     = (1 << swla_pkg::ELAP_W) - 1;
    localparam int     ELAP_NOMINAL = 1000;
    localparam longint LIMIT_L      = longint'(swla_pkg::LIMIT_MS);
    localparam int     RANDOM_ITEMS = 720;
    localparam int     LAP_RUN      = 20;
    localparam int     HOLD_AFTER   = 200;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     DRAIN_CYCLES = 8;
    localparam int     CYCLE_LIMIT  = 2_000_000;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY} t_rx_mode;

    // One command beat as it goes onto the input channel.
    typedef struct {
        logic [swla_pkg::CMD_W-1:0]  cmd;
        logic [swla_pkg::ELAP_W-1:0] elapsed;
        logic [swla_pkg::SEL_W-1:0]  sel;
    } t_key_beat;

    // One result beat as the watch should present it.
    typedef struct {
        logic [swla_pkg::MS_W-1:0]         total;
        logic [swla_pkg::MS_W-1:0]         alarm;
        logic                              fired;
        logic                              running;
        logic [swla_pkg::LAPS_W-1:0]       laps_taken;
        logic [swla_pkg::HELD_W-1:0]       laps_held;
        logic signed [swla_pkg::SCR_W-1:0] scroll;
        logic [swla_pkg::MS_W-1:0]         lap_value;
    } t_watch_view;

    // Clock, reset and block inputs, all known from time zero.
    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_in_valid   = 1'b0;
    logic [swla_pkg::CMD_W-1:0]  i_command    = '0;
    logic [swla_pkg::ELAP_W-1:0] i_elapsed_ms = '0;
    logic [swla_pkg::SEL_W-1:0]  i_lap_select = '0;
    logic                        i_out_stall  = 1'b0;

    logic                              o_in_stall;
    logic                              o_out_valid;
    logic [swla_pkg::MS_W-1:0]         o_watch_ms;
    logic [swla_pkg::MS_W-1:0]         o_alarm_ms;
    logic                              o_alarm_fired;
    logic                              o_running;
    logic [swla_pkg::LAPS_W-1:0]       o_laps_taken;
    logic [swla_pkg::HELD_W-1:0]       o_laps_held;
    logic signed [swla_pkg::SCR_W-1:0] o_scroll_offset;
    logic [swla_pkg::MS_W-1:0]         o_lap_value_ms;

    stopwatch_lap_alarm_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_elapsed_ms    (i_elapsed_ms),
        .i_lap_select    (i_lap_select),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_watch_ms      (o_watch_ms),
        .o_alarm_ms      (o_alarm_ms),
        .o_alarm_fired   (o_alarm_fired),
        .o_running       (o_running),
        .o_laps_taken    (o_laps_taken),
        .o_laps_held     (o_laps_held),
        .o_scroll_offset (o_scroll_offset),
        .o_lap_value_ms  (o_lap_value_ms)
    );

    always #10 i_clk = ~i_clk;

    // Pending command beats and predicted result beats.
    t_key_beat   key_queue[$];
    t_watch_view watch_expected[$];

    int n_queued   = 0;
    int n_sent     = 0;
    int n_checked  = 0;
    int n_fired    = 0;
    int n_wraps    = 0;
    int n_errors   = 0;
    int max_laps   = 0;
    bit steady     = 1'b0;
    bit gen_running = 1'b0;

    // Predicted watch state.
    longint sw_total;
    longint sw_alarm;
    bit     sw_armed;
    bit     sw_running;
    longint sw_laps[swla_pkg::LAP_DEPTH];
    int     sw_fill;
    int     sw_lap_count;
    int     sw_scroll;

    // Clears the watch; the alarm setting survives a clear command.
    function automatic void clear_watch(input bit keep_alarm);
        sw_total     = 0;
        sw_running   = 1'b0;
        sw_armed     = 1'b1;
        sw_fill      = 0;
        sw_lap_count = 0;
        sw_scroll    = 0;
        foreach (sw_laps[k]) sw_laps[k] = 0;
        if (!keep_alarm) sw_alarm = longint'(swla_pkg::ALARM_DEFAULT);
    endfunction

    // Moves the alarm by one step; anything outside 0 to 99 h becomes 0.
    function automatic void shift_alarm(input longint delta);
        longint a;
        a = sw_alarm + delta;
        if (a < 0 || a > LIMIT_L) a = 0;
        sw_alarm = a;
        sw_armed = 1'b1;
    endfunction

    // Applies one command beat and returns the result beat it should give.
    function automatic t_watch_view step_watch(input t_key_beat b);
        t_watch_view v;
        int          k;
        v.fired = 1'b0;
        case (b.cmd)
            swla_pkg::CMD_TICK:        if (sw_running) sw_total += b.elapsed;
            swla_pkg::CMD_RUN:         sw_running = !sw_running;
            swla_pkg::CMD_CLEAR:       clear_watch(1'b1);
            swla_pkg::CMD_LAP: begin
                if (sw_lap_count < int'(swla_pkg::LAPS_MAX)) sw_lap_count++;
                if (sw_fill < swla_pkg::LAP_DEPTH - 1) sw_fill++;
                for (k = sw_fill; k > 0; k--) sw_laps[k] = sw_laps[k - 1];
                sw_laps[0] = sw_total;
                sw_scroll  = 0;
            end
            swla_pkg::CMD_HOUR_UP:     shift_alarm(swla_pkg::HOUR_MS);
            swla_pkg::CMD_HOUR_DOWN:   shift_alarm(-swla_pkg::HOUR_MS);
            swla_pkg::CMD_MINUTE_UP:   shift_alarm(swla_pkg::MINUTE_MS);
            swla_pkg::CMD_MINUTE_DOWN: shift_alarm(-swla_pkg::MINUTE_MS);
            swla_pkg::CMD_SECOND_UP:   shift_alarm(swla_pkg::SECOND_MS);
            swla_pkg::CMD_SECOND_DOWN: shift_alarm(-swla_pkg::SECOND_MS);
            swla_pkg::CMD_SCROLL_DOWN: if (sw_scroll < 0) sw_scroll++;
            swla_pkg::CMD_SCROLL_UP: begin
                if (-sw_scroll < sw_fill - swla_pkg::PRINT_TURNS + 1) sw_scroll--;
            end
            default: ;
        endcase

        // The 99 h ceiling applies before the alarm comparison.
        if (sw_total > LIMIT_L) begin
            sw_total = 0;
            n_wraps++;
        end
        if (sw_total > sw_alarm && sw_armed) begin
            v.fired  = 1'b1;
            sw_armed = 1'b0;
        end

        v.total      = swla_pkg::MS_W'(sw_total);
        v.alarm      = swla_pkg::MS_W'(sw_alarm);
        v.running    = sw_running;
        v.laps_taken = swla_pkg::LAPS_W'(sw_lap_count);
        v.laps_held  = swla_pkg::HELD_W'(sw_fill);
        v.scroll     = swla_pkg::SCR_W'(sw_scroll);
        v.lap_value  = (b.sel < swla_pkg::LAP_DEPTH) ? swla_pkg::MS_W'(sw_laps[b.sel]) : '0;
        return v;
    endfunction

    // Queues one command beat and tracks the run state for the generator.
    task automatic push_key(input logic [swla_pkg::CMD_W-1:0] cmd, input int elapsed,
                            input int sel);
        t_key_beat b;
        b.cmd     = cmd;
        b.elapsed = swla_pkg::ELAP_W'(elapsed);
        b.sel     = swla_pkg::SEL_W'(sel);
        key_queue.push_back(b);
        n_queued++;
        if (cmd == swla_pkg::CMD_RUN) gen_running = !gen_running;
        if (cmd == swla_pkg::CMD_CLEAR) gen_running = 1'b0;
    endtask

    function automatic int rand_elapsed();
        if ($urandom_range(0, 3) != 0) return $urandom_range(0, ELAP_NOMINAL);
        return $urandom_range(0, ELAP_MAX);
    endfunction

    function automatic int rand_sel();
        return $urandom_range(0, (1 << swla_pkg::SEL_W) - 1);
    endfunction

    function automatic logic [swla_pkg::CMD_W-1:0] rand_adjust();
        return swla_pkg::CMD_W'($urandom_range(swla_pkg::CMD_HOUR_UP,
                                               swla_pkg::CMD_SECOND_DOWN));
    endfunction

    // Waits until every queued beat has gone and every result has come.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (key_queue.size() != 0 || i_in_valid || watch_expected.size() != 0);
    endtask

    // Driver: sends beats in bursts with random gaps and holds a stalled beat.
    t_key_beat on_wire;
    int        burst_left = 0;
    int        gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                watch_expected.push_back(step_watch(on_wire));
                n_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0 && !steady) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (key_queue.size() > 0) begin
                    on_wire = key_queue.pop_front();
                    i_command    <= on_wire.cmd;
                    i_elapsed_ms <= on_wire.elapsed;
                    i_lap_select <= on_wire.sel;
                    i_in_valid   <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold early in the random part.
    t_rx_mode rx_mode   = RX_FREE;
    int       mode_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (!hold_done && n_checked >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (steady) begin
            i_out_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(RX_FREE, RX_HEAVY));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_FREE:  i_out_stall <= 1'b0;
                RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                default:  i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // Monitor: every accepted result beat against the oldest prediction.
    t_watch_view want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (watch_expected.size() == 0) begin
                $error("result beat arrived with no command waiting for it");
                n_errors++;
            end else begin
                want = watch_expected.pop_front();
                check_field("watch_ms", want.total, o_watch_ms);
                check_field("alarm_ms", want.alarm, o_alarm_ms);
                check_field("alarm_fired", want.fired, o_alarm_fired);
                check_field("running", want.running, o_running);
                check_field("laps_taken", want.laps_taken, o_laps_taken);
                check_field("laps_held", want.laps_held, o_laps_held);
                check_field("scroll_offset", want.scroll, o_scroll_offset);
                check_field("lap_value_ms", want.lap_value, o_lap_value_ms);
                if (want.fired) n_fired++;
                if (int'(want.laps_taken) > max_laps) max_laps = int'(want.laps_taken);
            end
            n_checked++;
        end
    end

    // Watchdog on the whole run.
    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        int                         pick;
        int                         reps;
        int                         main_end;
        logic [swla_pkg::CMD_W-1:0] c;

        clear_watch(1'b0);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-store scrolls, paused tick, field extremes, every
        // alarm step, the alarm pushed below zero, spare codes and a clear.
        push_key(swla_pkg::CMD_SCROLL_UP, 0, 0);
        push_key(swla_pkg::CMD_SCROLL_DOWN, ELAP_MAX, 15);
        push_key(swla_pkg::CMD_TICK, ELAP_MAX, 0);
        push_key(swla_pkg::CMD_RUN, 0, 0);
        push_key(swla_pkg::CMD_TICK, 0, 0);
        push_key(swla_pkg::CMD_TICK, ELAP_MAX, 15);
        push_key(swla_pkg::CMD_TICK, ELAP_NOMINAL, 1);
        push_key(swla_pkg::CMD_LAP, 0, 0);
        push_key(swla_pkg::CMD_LAP, ELAP_MAX, 1);
        push_key(swla_pkg::CMD_HOUR_UP, 0, 2);
        push_key(swla_pkg::CMD_HOUR_DOWN, 0, 0);
        push_key(swla_pkg::CMD_MINUTE_UP, 0, 1);
        push_key(swla_pkg::CMD_MINUTE_DOWN, 0, 0);
        push_key(swla_pkg::CMD_SECOND_UP, 0, 1);
        push_key(swla_pkg::CMD_SECOND_DOWN, 0, 0);
        push_key(swla_pkg::CMD_HOUR_DOWN, 0, 0);
        push_key(swla_pkg::CMD_SECOND_DOWN, 0, 15);
        push_key(swla_pkg::CMD_RUN, 0, 0);
        push_key(swla_pkg::CMD_TICK, ELAP_MAX, 0);
        push_key(CMD_SPARE_FIRST, ELAP_MAX, 15);
        push_key(CMD_SPARE_LAST, 0, 0);
        push_key(swla_pkg::CMD_CLEAR, ELAP_MAX, 0);
        push_key(swla_pkg::CMD_RUN, 0, 0);

        // Alarm up to exactly 99 h, then one step past it clears it.
        repeat (99) push_key(swla_pkg::CMD_HOUR_UP, rand_elapsed(), rand_sel());
        push_key(swla_pkg::CMD_SECOND_UP, rand_elapsed(), rand_sel());
        push_key(swla_pkg::CMD_MINUTE_DOWN, rand_elapsed(), rand_sel());
        wait_idle();

        // Random command sequences, mostly well formed.
        main_end = n_queued + RANDOM_ITEMS;
        while (n_queued < main_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                if (!gen_running) push_key(swla_pkg::CMD_RUN, rand_elapsed(), rand_sel());
                reps = $urandom_range(4, 30);
                repeat (reps) push_key(swla_pkg::CMD_TICK, rand_elapsed(), rand_sel());
            end else if (pick < 50) begin
                reps = $urandom_range(1, 20);
                repeat (reps) begin
                    push_key(swla_pkg::CMD_LAP, rand_elapsed(), rand_sel());
                    if ($urandom_range(0, 1)) begin
                        push_key(swla_pkg::CMD_TICK, rand_elapsed(), rand_sel());
                    end
                end
            end else if (pick < 62) begin
                reps = $urandom_range(1, 14);
                repeat (reps) begin
                    c = ($urandom_range(0, 2) != 0) ? swla_pkg::CMD_SCROLL_UP :
                                                      swla_pkg::CMD_SCROLL_DOWN;
                    push_key(c, rand_elapsed(), rand_sel());
                end
            end else if (pick < 80) begin
                reps = $urandom_range(1, 6);
                repeat (reps) push_key(rand_adjust(), rand_elapsed(), rand_sel());
            end else if (pick < 84) begin
                c    = rand_adjust();
                reps = $urandom_range(20, 110);
                repeat (reps) push_key(c, rand_elapsed(), rand_sel());
            end else if (pick < 90) begin
                push_key(swla_pkg::CMD_RUN, rand_elapsed(), rand_sel());
            end else if (pick < 93) begin
                push_key(swla_pkg::CMD_CLEAR, rand_elapsed(), rand_sel());
            end else if (pick < 97) begin
                c = swla_pkg::CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
                push_key(c, rand_elapsed(), rand_sel());
            end else begin
                reps = $urandom_range(1, 5);
                repeat (reps) begin
                    c = swla_pkg::CMD_W'($urandom_range(swla_pkg::CMD_TICK, CMD_SPARE_LAST));
                    push_key(c, rand_elapsed(), rand_sel());
                end
            end
        end
        wait_idle();

        // Enough laps to fill the store and drop the oldest, then scroll it.
        steady = 1'b1;
        push_key(swla_pkg::CMD_CLEAR, 0, 0);
        push_key(swla_pkg::CMD_RUN, 0, 0);
        for (int k = 0; k < LAP_RUN; k++) begin
            push_key(swla_pkg::CMD_LAP, rand_elapsed(), rand_sel());
            if (k % 4 == 0) push_key(swla_pkg::CMD_TICK, rand_elapsed(), rand_sel());
        end
        repeat (12) push_key(swla_pkg::CMD_SCROLL_UP, rand_elapsed(), rand_sel());
        repeat (12) push_key(swla_pkg::CMD_SCROLL_DOWN, rand_elapsed(), rand_sel());
        push_key(swla_pkg::CMD_SCROLL_UP, rand_elapsed(), rand_sel());
        push_key(swla_pkg::CMD_LAP, rand_elapsed(), rand_sel());
        wait_idle();
        steady = 1'b0;

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (watch_expected.size() != 0) begin
            $error("%0d predicted results never arrived", watch_expected.size());
            n_errors++;
        end

        $display("Sent %0d commands and checked %0d results; the alarm fired %0d times.",
                 n_sent, n_checked, n_fired);
        $display("Highest lap count seen %0d; the total wrapped at 99 h %0d times.",
                 max_laps, n_wraps);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/swla_pkg.sv
sv/swla_lap_cell.sv
sv/swla_timer.sv
sv/stopwatch_lap_alarm_unit.sv
verif/tb.sv
